// File: rtl/core/lr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants for the line rasterizer: beat codes, register
// indexes, field widths and the structs passed between modules.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_W = 16;
    localparam int COLOR_W = 16;
    localparam int DELTA_W = 17;
    localparam int ERR_W   = 18;
    localparam int SCR_W   = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = 10'd320;
    localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = 10'd240;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0]        pixel_color;
        logic                      visible;
        logic                      last_pixel;
    } t_pixel;

    typedef struct packed {
        logic                      axes_swapped;
        logic signed [COORD_W-1:0] major_pos;
        logic signed [COORD_W-1:0] minor_pos;
        logic signed [COORD_W-1:0] major_end;
        logic [DELTA_W-1:0]        major_delta;
        logic [DELTA_W-1:0]        minor_delta;
        logic signed [ERR_W-1:0]   error_term;
        logic                      minor_step_down;
    } t_line_setup;

endpackage
`default_nettype wire

// File: rtl/core/lr_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_ifs
// Channel interfaces: command beats in, pixel beats out, register writes.
// ----------------------------------------------------------------------------
interface lr_in_if import lr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0]        draw_color;

    modport source (output valid, action, start_x, start_y, end_x, end_y, draw_color,
                    input ready);
    modport sink   (input valid, action, start_x, start_y, end_x, end_y, draw_color,
                    output ready);
endinterface

interface lr_out_if import lr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0]        pixel_color;
    logic                      visible;
    logic                      last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, visible, last_pixel,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, visible, last_pixel,
                    output ready);
endinterface

interface lr_cfg_if import lr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SCR_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/line_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line generator: a start beat sets up a line; while it is active, each
// step beat yields one pixel with visibility against the screen size and a last mark.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while the output buffer is not full;
// setup and step each finish in the accept cycle
// a two-entry output buffer keeps beats flowing while a pixel waits
// reset: idle, no line active, screen size 320 by 240, no clearing pass
// ----------------------------------------------------------------------------
module line_rasterizer import lr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lr_in_if.sink     i_item,
    lr_cfg_if.sink    i_cfg,
    lr_out_if.source  o_pixel
);

    logic                      r_busy, n_busy;
    logic                      r_axes_swapped, n_axes_swapped;
    logic signed [COORD_W-1:0] r_major_pos, n_major_pos;
    logic signed [COORD_W-1:0] r_minor_pos, n_minor_pos;
    logic signed [COORD_W-1:0] r_major_end, n_major_end;
    logic signed [ERR_W-1:0]   r_error_term, n_error_term;
    logic [DELTA_W-1:0]        r_major_delta, n_major_delta;
    logic [DELTA_W-1:0]        r_minor_delta, n_minor_delta;
    logic                      r_minor_step_down, n_minor_step_down;
    logic [COLOR_W-1:0]        r_line_color, n_line_color;
    logic [SCR_W-1:0]          r_screen_width;
    logic [SCR_W-1:0]          r_screen_height;

    t_line_setup               setup;
    t_pixel                    pix;
    t_pixel                    buf_data;
    logic                      buf_full;
    logic                      buf_valid;
    logic                      accept;
    logic                      push;
    logic                      is_last;
    logic signed [COORD_W-1:0] px, py;
    logic signed [ERR_W-1:0]   err_sub;

    lr_setup u_setup (
        .i_x0    (i_item.start_x),
        .i_y0    (i_item.start_y),
        .i_x1    (i_item.end_x),
        .i_y1    (i_item.end_y),
        .o_setup (setup)
    );

    assign i_item.ready = !buf_full;
    assign accept       = i_item.valid && i_item.ready;
    assign push         = accept && (i_item.action == ACT_STEP) && r_busy;

    // pixel for the current walk position
    always_comb begin
        px      = r_axes_swapped ? r_minor_pos : r_major_pos;
        py      = r_axes_swapped ? r_major_pos : r_minor_pos;
        is_last = (r_major_pos == r_major_end);
        pix.pixel_x     = px;
        pix.pixel_y     = py;
        pix.pixel_color = r_line_color;
        pix.visible     = !px[COORD_W-1] && !py[COORD_W-1]
                          && ({1'b0, px[COORD_W-2:0]} < COORD_W'(r_screen_width))
                          && ({1'b0, py[COORD_W-2:0]} < COORD_W'(r_screen_height));
        pix.last_pixel  = is_last;
    end

    always_comb begin
        n_busy            = r_busy;
        n_axes_swapped    = r_axes_swapped;
        n_major_pos       = r_major_pos;
        n_minor_pos       = r_minor_pos;
        n_major_end       = r_major_end;
        n_error_term      = r_error_term;
        n_major_delta     = r_major_delta;
        n_minor_delta     = r_minor_delta;
        n_minor_step_down = r_minor_step_down;
        n_line_color      = r_line_color;
        err_sub           = r_error_term - ERR_W'(r_minor_delta);

        if (accept && (i_item.action == ACT_START)) begin
            n_busy            = 1'b1;
            n_axes_swapped    = setup.axes_swapped;
            n_major_pos       = setup.major_pos;
            n_minor_pos       = setup.minor_pos;
            n_major_end       = setup.major_end;
            n_error_term      = setup.error_term;
            n_major_delta     = setup.major_delta;
            n_minor_delta     = setup.minor_delta;
            n_minor_step_down = setup.minor_step_down;
            n_line_color      = i_item.draw_color;
        end else if (push) begin
            if (err_sub[ERR_W-1]) begin
                n_minor_pos  = r_minor_step_down ? r_minor_pos - 16'sd1
                                                 : r_minor_pos + 16'sd1;
                n_error_term = err_sub + ERR_W'(r_major_delta);
            end else begin
                n_error_term = err_sub;
            end
            if (is_last) begin
                n_busy = 1'b0;
            end else begin
                n_major_pos = r_major_pos + 16'sd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy            <= 1'b0;
            r_axes_swapped    <= 1'b0;
            r_major_pos       <= '0;
            r_minor_pos       <= '0;
            r_major_end       <= '0;
            r_error_term      <= '0;
            r_major_delta     <= '0;
            r_minor_delta     <= '0;
            r_minor_step_down <= 1'b0;
            r_line_color      <= '0;
        end else begin
            r_busy            <= n_busy;
            r_axes_swapped    <= n_axes_swapped;
            r_major_pos       <= n_major_pos;
            r_minor_pos       <= n_minor_pos;
            r_major_end       <= n_major_end;
            r_error_term      <= n_error_term;
            r_major_delta     <= n_major_delta;
            r_minor_delta     <= n_minor_delta;
            r_minor_step_down <= n_minor_step_down;
            r_line_color      <= n_line_color;
        end
    end

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= SCREEN_WIDTH_RST;
            r_screen_height <= SCREEN_HEIGHT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg.data;
                REG_SCREEN_HEIGHT: r_screen_height <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    lr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (pix),
        .i_ready (o_pixel.ready),
        .o_valid (buf_valid),
        .o_data  (buf_data),
        .o_full  (buf_full)
    );

    assign o_pixel.valid       = buf_valid;
    assign o_pixel.pixel_x     = buf_data.pixel_x;
    assign o_pixel.pixel_y     = buf_data.pixel_y;
    assign o_pixel.pixel_color = buf_data.pixel_color;
    assign o_pixel.visible     = buf_data.visible;
    assign o_pixel.last_pixel  = buf_data.last_pixel;

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.action == ACT_START)) |=> r_busy)
        else $error("start beat did not open a line");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && is_last) |=> !r_busy)
        else $error("line still active after last pixel");

    a_major_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !is_last) |=> (r_major_pos == $past(r_major_pos) + 16'sd1))
        else $error("major position did not advance on step");

    a_idle_step_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.action == ACT_STEP) && !r_busy)
            |=> (!r_busy && $stable(r_major_pos) && $stable(r_minor_pos)))
        else $error("step while idle changed the walk");

endmodule
`default_nettype wire

// File: rtl/core/lr_setup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_setup
// Line setup: classes the line as steep, swaps axes, orders the endpoints and
// derives the deltas, minor direction and initial error.
// ----------------------------------------------------------------------------
module lr_setup import lr_pkg::*; (
    input  wire logic signed [COORD_W-1:0] i_x0,
    input  wire logic signed [COORD_W-1:0] i_y0,
    input  wire logic signed [COORD_W-1:0] i_x1,
    input  wire logic signed [COORD_W-1:0] i_y1,
    output t_line_setup                    o_setup
);

    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [DELTA_W-1:0]        adx;
    logic [DELTA_W-1:0]        ady;
    logic                      steep;
    logic signed [COORD_W-1:0] a0, a1, b0, b1;
    logic signed [COORD_W-1:0] ma0, ma1, mi0, mi1;
    logic signed [DELTA_W-1:0] dmin;
    logic [DELTA_W-1:0]        maj_d;

    always_comb begin
        dx    = DELTA_W'(i_x1) - DELTA_W'(i_x0);
        dy    = DELTA_W'(i_y1) - DELTA_W'(i_y0);
        adx   = dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
        ady   = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);
        steep = ady > adx;

        a0 = steep ? i_y0 : i_x0;
        b0 = steep ? i_x0 : i_y0;
        a1 = steep ? i_y1 : i_x1;
        b1 = steep ? i_x1 : i_y1;

        if (a0 > a1) begin
            ma0 = a1;
            ma1 = a0;
            mi0 = b1;
            mi1 = b0;
        end else begin
            ma0 = a0;
            ma1 = a1;
            mi0 = b0;
            mi1 = b1;
        end

        maj_d = DELTA_W'(DELTA_W'(ma1) - DELTA_W'(ma0));
        dmin  = DELTA_W'(mi1) - DELTA_W'(mi0);

        o_setup.axes_swapped    = steep;
        o_setup.major_pos       = ma0;
        o_setup.minor_pos       = mi0;
        o_setup.major_end       = ma1;
        o_setup.major_delta     = maj_d;
        o_setup.minor_delta     = dmin[DELTA_W-1] ? DELTA_W'(-dmin) : DELTA_W'(dmin);
        o_setup.error_term      = ERR_W'({1'b0, maj_d[DELTA_W-1:1]});
        o_setup.minor_step_down = !(mi0 < mi1);
    end

endmodule
`default_nettype wire

// File: rtl/core/lr_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_out_buf
// Two-entry pixel output buffer: output register plus skid stage, so the
// walk keeps taking beats while a pixel waits to be taken.
// ----------------------------------------------------------------------------
module lr_out_buf import lr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_pixel i_data,
    input  wire logic   i_ready,
    output logic        o_valid,
    output t_pixel      o_data,
    output logic        o_full
);

    logic   r_main_vld, n_main_vld;
    logic   r_skid_vld, n_skid_vld;
    t_pixel r_main, n_main;
    t_pixel r_skid, n_skid;
    logic   pop;

    always_comb begin
        pop        = r_main_vld && i_ready;
        n_main_vld = r_main_vld;
        n_skid_vld = r_skid_vld;
        n_main     = r_main;
        n_skid     = r_skid;
        if (i_push) begin
            if (!r_main_vld || pop) begin
                n_main     = i_data;
                n_main_vld = 1'b1;
            end else begin
                n_skid     = i_data;
                n_skid_vld = 1'b1;
            end
        end else if (pop) begin
            if (r_skid_vld) begin
                n_main     = r_skid;
                n_skid_vld = 1'b0;
            end else begin
                n_main_vld = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_main_vld <= n_main_vld;
            r_skid_vld <= n_skid_vld;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_valid = r_main_vld;
    assign o_data  = r_main;
    assign o_full  = r_skid_vld;

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_main_vld)
        else $error("skid entry held without output entry");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> !i_push)
        else $error("pixel pushed into full buffer");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && i_ready) |=> (r_main_vld && !r_skid_vld))
        else $error("skid entry not moved forward on pop");

endmodule
`default_nettype wire

// File: verif/lr_pixel_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_pixel_scoreboard
// Watches the command, register and pixel channels of the line rasterizer.
// Keeps its own Bresenham walk and screen size, queues the pixel that each
// accepted step beat should give, and compares every accepted pixel beat
// against the oldest queued pixel. Failures are counted for the top.
// ----------------------------------------------------------------------------
module lr_pixel_scoreboard import lr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lr_in_if          i_item,
    lr_cfg_if         i_cfg,
    lr_out_if         i_pixel,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int REPORT_MAX = 10;

    logic [SCR_W-1:0]   scr_width;
    logic [SCR_W-1:0]   scr_height;
    logic               line_active;
    logic [COLOR_W-1:0] line_color;
    t_line_setup        walk;
    t_pixel             pending_pixels[$];
    int                 fail_count;

    task automatic plan_line(input logic signed [COORD_W-1:0] sx, sy, ex, ey,
                             input logic [COLOR_W-1:0] colour);
        int x0, y0, x1, y1, t;
        x0 = sx;
        y0 = sy;
        x1 = ex;
        y1 = ey;
        walk.axes_swapped = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
        if (walk.axes_swapped) begin
            t = x0; x0 = y0; y0 = t;
            t = x1; x1 = y1; y1 = t;
        end
        if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
        end
        walk.major_pos       = x0[COORD_W-1:0];
        walk.major_end       = x1[COORD_W-1:0];
        walk.minor_pos       = y0[COORD_W-1:0];
        walk.major_delta     = DELTA_W'(x1 - x0);
        walk.minor_delta     = DELTA_W'((y1 > y0) ? y1 - y0 : y0 - y1);
        walk.error_term      = ERR_W'((x1 - x0) / 2);
        walk.minor_step_down = !(y0 < y1);
        line_color  = colour;
        line_active = 1'b1;
    endtask

    function automatic t_pixel walk_pixel();
        t_pixel px;
        int     err;
        px.pixel_x     = walk.axes_swapped ? walk.minor_pos : walk.major_pos;
        px.pixel_y     = walk.axes_swapped ? walk.major_pos : walk.minor_pos;
        px.pixel_color = line_color;
        px.visible     = (px.pixel_x >= 0) && (px.pixel_y >= 0) &&
                         (int'(px.pixel_x) < int'(scr_width)) &&
                         (int'(px.pixel_y) < int'(scr_height));
        px.last_pixel  = (walk.major_pos == walk.major_end);
        err = int'(walk.error_term) - int'(walk.minor_delta);
        if (err < 0) begin
            walk.minor_pos = walk.minor_step_down ? walk.minor_pos - 1'b1
                                                  : walk.minor_pos + 1'b1;
            err = err + int'(walk.major_delta);
        end
        walk.error_term = ERR_W'(err);
        if (px.last_pixel) begin
            line_active = 1'b0;
        end else begin
            walk.major_pos = walk.major_pos + 1'b1;
        end
        return px;
    endfunction

    always @(posedge i_clk) begin
        t_pixel want;
        t_pixel got;
        if (!i_rst_n) begin
            scr_width   = SCREEN_WIDTH_RST;
            scr_height  = SCREEN_HEIGHT_RST;
            line_active = 1'b0;
            line_color  = '0;
            walk        = '0;
            fail_count  = 0;
            pending_pixels.delete();
        end else begin
            // pixel side first: a pixel never belongs to a step taken this edge
            if (i_pixel.valid && i_pixel.ready) begin
                got.pixel_x     = i_pixel.pixel_x;
                got.pixel_y     = i_pixel.pixel_y;
                got.pixel_color = i_pixel.pixel_color;
                got.visible     = i_pixel.visible;
                got.last_pixel  = i_pixel.last_pixel;
                if (pending_pixels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: unexpected pixel x=%0d y=%0d colour=%h vis=%b last=%b",
                                 $realtime, got.pixel_x, got.pixel_y, got.pixel_color,
                                 got.visible, got.last_pixel);
                end else begin
                    want = pending_pixels.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display({"%0t: pixel mismatch: expected x=%0d y=%0d colour=%h ",
                                      "vis=%b last=%b, got x=%0d y=%0d colour=%h vis=%b last=%b"},
                                     $realtime, want.pixel_x, want.pixel_y, want.pixel_color,
                                     want.visible, want.last_pixel, got.pixel_x, got.pixel_y,
                                     got.pixel_color, got.visible, got.last_pixel);
                    end
                end
            end
            // a step on the same edge as a register write still sees the old size
            if (i_item.valid && i_item.ready) begin
                if (i_item.action == ACT_START) begin
                    plan_line(i_item.start_x, i_item.start_y, i_item.end_x, i_item.end_y,
                              i_item.draw_color);
                end else if (line_active) begin
                    pending_pixels.push_back(walk_pixel());
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_SCREEN_WIDTH: begin
                        scr_width = i_cfg.data;
                    end
                    REG_SCREEN_HEIGHT: begin
                        scr_height = i_cfg.data;
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_pixels.size();
    end

endmodule

// File: verif/tb_line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_rasterizer
// Drives start and step beats into the line rasterizer with random gaps and
// a randomly stalling pixel sink, across several screen sizes. A short
// directed run covers single points, extreme endpoints, screen edges, steep
// and reversed lines and steps with no line; random lines follow, mostly
// complete, some overrun and some abandoned by a new start.
// ----------------------------------------------------------------------------
module tb_line_rasterizer;
    import lr_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int NUM_PHASES    = 7;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 500000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lr_in_if  item_bus ();
    lr_cfg_if cfg_bus ();
    lr_out_if pix_bus ();

    int               fail_count;
    int               pending;
    int               sent_items;
    int               sink_wait;
    int               watch_cycles;
    bit               src_burst;
    bit               sink_burst;
    logic [SCR_W-1:0] cur_width;
    logic [SCR_W-1:0] cur_height;
    int               phase_width [NUM_PHASES] = '{320, 1, 1023, 0, 1023, 512, 0};
    int               phase_height[NUM_PHASES] = '{240, 1, 1023, 1023, 0, 384, 0};

    line_rasterizer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .i_cfg   (cfg_bus),
        .o_pixel (pix_bus)
    );

    lr_pixel_scoreboard i_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_bus),
        .i_cfg        (cfg_bus),
        .i_pixel      (pix_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int draw_gap(input bit burst);
        if (burst)
            return 0;
        return $urandom_range(16, 0);
    endfunction

    function automatic int rand_word();
        logic signed [COORD_W-1:0] w;
        w = COORD_W'($urandom);
        return int'(w);
    endfunction

    // pixel sink: fresh stall after every accepted beat
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            sink_wait     <= 0;
            pix_bus.ready <= 1'b0;
        end else begin
            n = sink_wait;
            if (pix_bus.valid && pix_bus.ready) begin
                if ($urandom_range(23, 0) == 0)
                    sink_burst = !sink_burst;
                n = draw_gap(sink_burst);
            end else if (n > 0) begin
                n--;
            end
            sink_wait     <= n;
            pix_bus.ready <= (n == 0);
        end
    end

    task automatic send_beat(input t_action act,
                             input logic signed [COORD_W-1:0] sx, sy, ex, ey,
                             input logic [COLOR_W-1:0] colour);
        int gap;
        if ($urandom_range(23, 0) == 0)
            src_burst = !src_burst;
        gap = draw_gap(src_burst);
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.action     <= act;
        item_bus.start_x    <= sx;
        item_bus.start_y    <= sy;
        item_bus.end_x      <= ex;
        item_bus.end_y      <= ey;
        item_bus.draw_color <= colour;
        do @(posedge i_clk); while (!item_bus.ready);
        sent_items++;
    endtask

    task automatic step_beat();
        send_beat(ACT_STEP, COORD_W'(rand_word()), COORD_W'(rand_word()),
                  COORD_W'(rand_word()), COORD_W'(rand_word()), COLOR_W'($urandom));
    endtask

    task automatic random_line();
        int x0, y0, x1, y1, reach, length, steps, pick;
        pick = $urandom_range(99, 0);
        if (pick < 10) begin
            x0 = rand_word();
            y0 = rand_word();
            x1 = rand_word();
            y1 = rand_word();
        end else begin
            reach = (pick < 80) ? 12 : 40;
            x0 = int'($urandom_range(cur_width + 15, 0)) - 8;
            y0 = int'($urandom_range(cur_height + 15, 0)) - 8;
            x1 = x0 + int'($urandom_range(2 * reach, 0)) - reach;
            y1 = y0 + int'($urandom_range(2 * reach, 0)) - reach;
        end
        length = (x1 > x0) ? x1 - x0 : x0 - x1;
        if (((y1 > y0) ? y1 - y0 : y0 - y1) > length)
            length = (y1 > y0) ? y1 - y0 : y0 - y1;
        length++;
        pick = $urandom_range(99, 0);
        if (length > 100)
            steps = $urandom_range(30, 0);
        else if (pick < 75)
            steps = length;
        else if (pick < 85)
            steps = length + $urandom_range(3, 1);
        else
            steps = $urandom_range(length - 1, 0);
        send_beat(ACT_START, COORD_W'(x0), COORD_W'(y0), COORD_W'(x1), COORD_W'(y1),
                  COLOR_W'($urandom));
        repeat (steps) step_beat();
    endtask

    task automatic settle();
        item_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_screen(input logic [SCR_W-1:0] w, h);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= REG_SCREEN_WIDTH;
        cfg_bus.data  <= w;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.index <= REG_SCREEN_HEIGHT;
        cfg_bus.data  <= h;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        cur_width  = w;
        cur_height = h;
    endtask

    initial begin
        for (watch_cycles = 0; watch_cycles < CYCLE_LIMIT; watch_cycles++)
            @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int quota;
        i_rst_n             <= 1'b0;
        item_bus.valid      <= 1'b0;
        item_bus.action     <= ACT_STEP;
        item_bus.start_x    <= '0;
        item_bus.start_y    <= '0;
        item_bus.end_x      <= '0;
        item_bus.end_y      <= '0;
        item_bus.draw_color <= '0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= REG_SCREEN_WIDTH;
        cfg_bus.data        <= '0;
        cur_width  = SCREEN_WIDTH_RST;
        cur_height = SCREEN_HEIGHT_RST;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // step with no line, then a single point
        step_beat();
        send_beat(ACT_START, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000);
        step_beat();
        step_beat();
        // extreme endpoints, abandoned by the next start
        send_beat(ACT_START, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'hFFFF);
        step_beat();
        step_beat();
        // across the bottom right screen corner
        send_beat(ACT_START, 16'sd319, 16'sd239, 16'sd320, 16'sd240, 16'hA5A5);
        step_beat();
        step_beat();
        // steep with the minor axis falling
        send_beat(ACT_START, 16'sd3, 16'sd0, 16'sd1, 16'sd4, 16'h5A5A);
        repeat (5) step_beat();
        // shallow, endpoints given in reverse
        send_beat(ACT_START, 16'sd4, 16'sd2, 16'sd0, 16'sd1, 16'h07E0);
        repeat (5) step_beat();

        quota = RANDOM_ITEMS / NUM_PHASES;
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                settle();
                if (p == NUM_PHASES - 1)
                    write_screen(SCR_W'($urandom_range(1023, 1)),
                                 SCR_W'($urandom_range(1023, 1)));
                else
                    write_screen(SCR_W'(phase_width[p]), SCR_W'(phase_height[p]));
            end
            sent_items = 0;
            while (sent_items < quota)
                random_line();
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
